// ===== rtl/rgbconv_pkg.sv =====
// Shared constants, types and register codes for the 5x5 RGB convolution block.
// Used by the channel interfaces, the line buffer, the filter datapath and the top level.
// No dependencies.
`default_nettype none

package rgbconv_pkg;

   // Geometry
   localparam int MAX_LINE_PIXELS = 1024;
   localparam int KERNEL_SIZE     = 5;
   localparam int HIST_ROWS       = KERNEL_SIZE - 1;
   localparam int TAP_STRIDE      = 3;                              // interleaved R,G,B
   localparam int WIN_KEEP        = TAP_STRIDE * (KERNEL_SIZE - 1); // stored window columns
   localparam int NUM_COEFS       = KERNEL_SIZE * KERNEL_SIZE;
   localparam int STORE_DEPTH     = MAX_LINE_PIXELS * TAP_STRIDE;   // bytes per longest line
   localparam int EMIT_COL        = WIN_KEEP;                       // first column with output

   // Widths
   localparam int SAMPLE_W    = 8;
   localparam int COEF_W      = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int LINE_PIX_W  = 11;
   localparam int LANES       = CSR_DATA_W / COEF_W;
   localparam int COL_W       = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROWS_W      = $clog2(HIST_ROWS + 1);
   localparam int HIST_W      = HIST_ROWS * SAMPLE_W;

   localparam logic [SAMPLE_W-1:0] PIXEL_MAX = {SAMPLE_W{1'b1}};

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_WORD_0        = 3'd0,
      CSR_COEF_WORD_1        = 3'd1,
      CSR_COEF_WORD_2        = 3'd2,
      CSR_COEF_WORD_3        = 3'd3,
      CSR_COEF_WORD_4        = 3'd4,
      CSR_COEF_WORD_5        = 3'd5,
      CSR_COEF_WORD_6        = 3'd6,
      CSR_PADDED_LINE_PIXELS = 3'd7
   } csr_index_type;

   typedef logic [NUM_COEFS-1:0][COEF_W-1:0]   coef_vec_type;
   typedef logic [NUM_COEFS-1:0][SAMPLE_W-1:0] tap_vec_type;

   // Window tap control (valid, line end) handed from line buffer to filter
   typedef struct packed {
      logic valid;
      logic line_end;
   } tap_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/rgbconv_if.sv =====
// Valid/ready channel interfaces: source bytes, filtered results, register writes.
// Depends on rgbconv_pkg for field widths.
`default_nettype none

interface rgbconv_req_if import rgbconv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface rgbconv_rsp_if import rgbconv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] pixel_out;
   logic                line_end;

   modport source (output valid, output pixel_out, output line_end, input ready);
   modport sink   (input valid, input pixel_out, input line_end, output ready);
endinterface

interface rgbconv_csr_if import rgbconv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_5x5_convolution.sv =====
// Path: a transferred byte passes the stage 1 register, the product register, the row-sum
// register and the result register before it is offered on rsp.
// Throughput: one byte per cycle while rsp is not stalled; the line store has one read and one
// write port, each used once per byte; a line buffer stage feeds a three-stage filter pipeline.
// Reset: clears counters, pipeline valids, coefficients (to 0) and line width (1024 pixels).
// Line store and window are not cleared; a frame_start byte restarts the raster.
`default_nettype none

module rgb_5x5_convolution import rgbconv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rgbconv_req_if.sink   req_bus,
   rgbconv_rsp_if.source rsp_bus,
   rgbconv_csr_if.sink   csr_bus
);

   coef_vec_type     coef_ff, coef_in;
   logic [COL_W-1:0] line_bytes_ff, line_bytes_in;
   tap_ctrl_type     tap_ctrl;
   tap_vec_type      taps;
   logic             tap_ready;

   // Bytes per line from the pixel count, clamped to the supported range
   function automatic logic [COL_W-1:0] line_bytes_of(input logic [LINE_PIX_W-1:0] pix);
      logic [LINE_PIX_W-1:0] p;
      p = pix;
      if (p < LINE_PIX_W'(KERNEL_SIZE)) begin
         p = LINE_PIX_W'(KERNEL_SIZE);
      end
      if (p > LINE_PIX_W'(MAX_LINE_PIXELS)) begin
         p = LINE_PIX_W'(MAX_LINE_PIXELS);
      end
      return (COL_W'(p) << 1) + COL_W'(p);
   endfunction

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_comb begin
      coef_in       = coef_ff;
      line_bytes_in = line_bytes_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_COEF_WORD_0, CSR_COEF_WORD_1, CSR_COEF_WORD_2,
            CSR_COEF_WORD_3, CSR_COEF_WORD_4, CSR_COEF_WORD_5: begin
               for (int lane = 0; lane < LANES; lane++) begin
                  coef_in[LANES*int'(csr_bus.index) + lane] =
                     csr_bus.data[COEF_W*lane +: COEF_W];
               end
            end
            CSR_COEF_WORD_6: begin
               coef_in[NUM_COEFS-1] = csr_bus.data[COEF_W-1:0];
            end
            CSR_PADDED_LINE_PIXELS: begin
               line_bytes_in = line_bytes_of(csr_bus.data[LINE_PIX_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff       <= '0;
         line_bytes_ff <= COL_W'(STORE_DEPTH);
      end else begin
         coef_ff       <= coef_in;
         line_bytes_ff <= line_bytes_in;
      end
   end

   rgbconv_linebuf u_linebuf (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_bus.valid),
      .in_ready       (req_bus.ready),
      .in_sample      (req_bus.sample),
      .in_frame_start (req_bus.frame_start),
      .line_bytes     (line_bytes_ff),
      .out_ctrl       (tap_ctrl),
      .out_taps       (taps),
      .out_ready      (tap_ready)
   );

   rgbconv_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .coefs     (coef_ff),
      .in_ctrl   (tap_ctrl),
      .in_taps   (taps),
      .in_ready  (tap_ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .pixel_out (rsp_bus.pixel_out),
      .line_end  (rsp_bus.line_end)
   );

endmodule

`default_nettype wire

// ===== rtl/rgbconv_linebuf.sv =====
// Line store, raster counters and 5x13 byte window; presents the 25 filter taps.
// Depends on rgbconv_pkg.
`default_nettype none

module rgbconv_linebuf import rgbconv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic                in_frame_start,
   input  logic [COL_W-1:0]    line_bytes,
   output tap_ctrl_type        out_ctrl,
   output tap_vec_type         out_taps,
   input  logic                out_ready
);

   logic [COL_W-1:0]  col_ff, col_in, col_eff, col_inc;
   logic [ROWS_W-1:0] rows_ff, rows_in, rows_eff;
   logic              accept, wrap, emit;

   logic                s1_valid_ff, s1_valid_in, s1_adv;
   logic                s1_emit_ff, s1_line_end_ff;
   logic [ADDR_W-1:0]   s1_addr_ff, rd_addr;
   logic [SAMPLE_W-1:0] s1_sample_ff;

   logic [HIST_W-1:0] mem [STORE_DEPTH];
   logic [HIST_W-1:0] rd_word_ff, fwd_word_ff, hist_word, wr_word;
   logic              fwd_hit_ff;

   logic [SAMPLE_W-1:0] win_ff [KERNEL_SIZE][WIN_KEEP];
   logic [SAMPLE_W-1:0] column [KERNEL_SIZE];

   // Handshake: stage 1 frees when its item moves on (non-emitting items just retire)
   assign s1_adv   = s1_valid_ff && (!s1_emit_ff || out_ready);
   assign in_ready = !s1_valid_ff || s1_adv;
   assign accept   = in_valid && in_ready;

   // Raster position of the incoming byte and next counter values
   always_comb begin
      col_eff = in_frame_start ? '0 : col_ff;
      if (col_eff >= COL_W'(STORE_DEPTH)) begin
         col_eff = '0;
      end
      rows_eff = in_frame_start ? '0 : rows_ff;
      col_inc  = col_eff + COL_W'(1);
      wrap     = col_inc >= line_bytes;
      emit     = (rows_eff == ROWS_W'(HIST_ROWS)) && (col_eff >= COL_W'(EMIT_COL));
      col_in   = col_ff;
      rows_in  = rows_ff;
      if (accept) begin
         col_in  = wrap ? '0 : col_inc;
         rows_in = rows_eff;
         if (wrap && rows_eff < ROWS_W'(HIST_ROWS)) begin
            rows_in = rows_eff + ROWS_W'(1);
         end
      end
   end

   assign rd_addr     = col_eff[ADDR_W-1:0];
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         rows_ff     <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         rows_ff     <= rows_in;
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            fwd_hit_ff <= s1_adv && (s1_addr_ff == rd_addr);
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff     <= emit;
         s1_line_end_ff <= wrap;
         s1_addr_ff     <= rd_addr;
         s1_sample_ff   <= in_sample;
         fwd_word_ff    <= wr_word;
      end
   end

   // Line store: read on transfer, write the shifted column back as the item leaves stage 1
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         mem[s1_addr_ff] <= wr_word;
      end
      if (accept) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Same-address write in the read cycle (back-to-back frame starts) is forwarded
   assign hist_word = fwd_hit_ff ? fwd_word_ff : rd_word_ff;
   assign wr_word   = {s1_sample_ff, hist_word[HIST_W-1:SAMPLE_W]};

   // Column of five stacked bytes, oldest line first
   always_comb begin
      for (int k = 0; k < HIST_ROWS; k++) begin
         column[k] = hist_word[SAMPLE_W*k +: SAMPLE_W];
      end
      column[HIST_ROWS] = s1_sample_ff;
   end

   // Window shift line
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int j = 0; j < WIN_KEEP - 1; j++) begin
               win_ff[r][j] <= win_ff[r][j+1];
            end
            win_ff[r][WIN_KEEP-1] <= column[r];
         end
      end
   end

   // Taps as the window will look after this shift; rightmost tap is the new column
   always_comb begin
      for (int fy = 0; fy < KERNEL_SIZE; fy++) begin
         for (int fx = 0; fx < KERNEL_SIZE; fx++) begin
            if (fx < KERNEL_SIZE - 1) begin
               out_taps[fy*KERNEL_SIZE + fx] = win_ff[fy][TAP_STRIDE*fx];
            end else begin
               out_taps[fy*KERNEL_SIZE + fx] = column[fy];
            end
         end
      end
   end

   assign out_ctrl.valid    = s1_valid_ff && s1_emit_ff;
   assign out_ctrl.line_end = s1_line_end_ff;

endmodule

`default_nettype wire

// ===== rtl/rgbconv_filter.sv =====
// Filter datapath: 25 products, row sums, total, clamp and result register.
// Depends on rgbconv_pkg.
`default_nettype none

module rgbconv_filter import rgbconv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  coef_vec_type        coefs,
   input  tap_ctrl_type        in_ctrl,
   input  tap_vec_type         in_taps,
   output logic                in_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] pixel_out,
   output logic                line_end
);

   logic [COEF_W-1:0]   prod_ff   [NUM_COEFS];
   logic [COEF_W-1:0]   rowsum_ff [KERNEL_SIZE];
   logic [COEF_W-1:0]   rowsum_in [KERNEL_SIZE];
   logic [COEF_W-1:0]   total;
   logic [SAMPLE_W-1:0] clamped;

   logic s2_valid_ff, s2_line_end_ff;
   logic s3_valid_ff, s3_line_end_ff;
   logic out_valid_ff, out_line_end_ff;
   logic [SAMPLE_W-1:0] out_pixel_ff;
   logic free2, free3, free4;

   // Each stage takes a new item when empty or when its item moves on
   assign free4    = !out_valid_ff || rsp_ready;
   assign free3    = !s3_valid_ff || free4;
   assign free2    = !s2_valid_ff || free3;
   assign in_ready = free2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (free2) s2_valid_ff  <= in_ctrl.valid;
         if (free3) s3_valid_ff  <= s2_valid_ff;
         if (free4) out_valid_ff <= s3_valid_ff;
      end
   end

   // Products wrap at 16 bits
   always_ff @(posedge clock) begin
      if (in_ctrl.valid && free2) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            prod_ff[i] <= COEF_W'(COEF_W'(in_taps[i]) * coefs[i]);
         end
         s2_line_end_ff <= in_ctrl.line_end;
      end
   end

   // Per-row sums
   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         rowsum_in[r] = '0;
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            rowsum_in[r] = rowsum_in[r] + prod_ff[r*KERNEL_SIZE + c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && free3) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            rowsum_ff[r] <= rowsum_in[r];
         end
         s3_line_end_ff <= s2_line_end_ff;
      end
   end

   // Total, read as signed, clamped to 0..255
   always_comb begin
      total = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         total = total + rowsum_ff[r];
      end
      if (total[COEF_W-1]) begin
         clamped = '0;
      end else if (total > COEF_W'(PIXEL_MAX)) begin
         clamped = PIXEL_MAX;
      end else begin
         clamped = total[SAMPLE_W-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (s3_valid_ff && free4) begin
         out_pixel_ff    <= clamped;
         out_line_end_ff <= s3_line_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign pixel_out = out_pixel_ff;
   assign line_end  = out_line_end_ff;

endmodule

`default_nettype wire

// ===== rtl/rgbconv_checker.sv =====
// Port-level checks for rgb_5x5_convolution, attached by bind.
// Depends on rgbconv_pkg and the top level's channel interfaces.
`default_nettype none

module rgbconv_checker import rgbconv_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] pixel_out,
   input logic                line_end
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Reset empties the pipeline: no result can be offered while its stages refill
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result appeared too soon after reset");

   // After reset the input side is open
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // Stalled result payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(pixel_out) && $stable(line_end))
      else $error("rsp payload changed while stalled");

endmodule

bind rgb_5x5_convolution rgbconv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pixel_out (rsp_bus.pixel_out),
   .line_end  (rsp_bus.line_end)
);

`default_nettype wire

// ===== test/tb_rgb_5x5_convolution.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_5x5_convolution: streams padded RGB rows, predicts
// every filtered byte and compares it with the rsp channel. Depends on rgbconv_pkg,
// the channel interfaces in rgbconv_if.sv and the rgb_5x5_convolution top level.

module tb_rgb_5x5_convolution;
   import rgbconv_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 8;     // pipeline is four stages deep
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
   localparam int RANDOM_ITEMS   = 150;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pixel;
      logic                line_end;
   } pixel_result_type;

   typedef enum int {KERNEL_FULL, KERNEL_SPARSE, KERNEL_TAP} kernel_style_type;

   logic clock;
   logic reset;

   rgbconv_req_if req_ch ();
   rgbconv_rsp_if rsp_ch ();
   rgbconv_csr_if csr_ch ();

   rgb_5x5_convolution u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   // Filter state mirrored from the block
   coef_vec_type          kernel_coef;
   logic [LINE_PIX_W-1:0] line_pixels;
   logic [SAMPLE_W-1:0]   row_history [HIST_ROWS*STORE_DEPTH];
   logic [SAMPLE_W-1:0]   window_bytes [KERNEL_SIZE][WIN_KEEP+1];
   int unsigned           raster_col;
   int unsigned           rows_done;

   pixel_result_type pending_pixels[$];
   int            mismatch_count;
   int            result_count;
   int            items_sent;
   int            idle_cycles;
   int            stall_left;
   bit            req_gaps_on;
   bit            rsp_stalls_on;

   always #(CLK_PERIOD/2) clock = ~clock;

   // Bytes per padded line, with the width clamped the way the block does it
   function automatic int unsigned line_len(int unsigned pixels);
      if (pixels < KERNEL_SIZE) pixels = KERNEL_SIZE;
      if (pixels > MAX_LINE_PIXELS) pixels = MAX_LINE_PIXELS;
      return pixels * TAP_STRIDE;
   endfunction

   // Mostly no gap, sometimes a few cycles, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return PIXEL_MAX;
      return SAMPLE_W'($urandom);
   endfunction

   function automatic coef_vec_type random_kernel(kernel_style_type style);
      coef_vec_type k;
      for (int i = 0; i < NUM_COEFS; i++) begin
         case (style)
            KERNEL_FULL:   k[i] = COEF_W'($urandom);
            KERNEL_SPARSE: k[i] = ($urandom_range(0, 9) < 7) ? '0
                                  : COEF_W'($urandom_range(0, 4) - 2);
            default:       k[i] = '0;
         endcase
      end
      if (style == KERNEL_TAP)
         k[$urandom_range(0, NUM_COEFS-1)] = COEF_W'($urandom_range(1, 3));
      return k;
   endfunction

   // Predict the result (if any) of one accepted byte
   task automatic convolve_byte(input logic [SAMPLE_W-1:0] value, input logic start);
      int unsigned         len;
      int unsigned         base;
      logic [SAMPLE_W-1:0] column [KERNEL_SIZE];
      logic [COEF_W-1:0]   acc;
      pixel_result_type    res;
      len = line_len(int'(line_pixels));
      if (start) begin
         raster_col = 0;
         rows_done  = 0;
      end
      if (raster_col >= STORE_DEPTH) raster_col = 0;

      // vertical column, oldest line first; history shifts up by one line
      base = raster_col * HIST_ROWS;
      for (int k = 0; k < HIST_ROWS; k++) column[k] = row_history[base + k];
      column[HIST_ROWS] = value;
      for (int k = 0; k < HIST_ROWS; k++) row_history[base + k] = column[k + 1];

      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < WIN_KEEP; c++) window_bytes[r][c] = window_bytes[r][c + 1];
         window_bytes[r][WIN_KEEP] = column[r];
      end

      // 16-bit wrapping sum, read as signed, clamped to a byte
      if (rows_done >= HIST_ROWS && raster_col >= EMIT_COL) begin
         acc = '0;
         for (int fy = 0; fy < KERNEL_SIZE; fy++)
            for (int fx = 0; fx < KERNEL_SIZE; fx++)
               acc = acc + COEF_W'(window_bytes[fy][TAP_STRIDE*fx])
                         * kernel_coef[fy*KERNEL_SIZE + fx];
         res.pixel    = acc[COEF_W-1] ? '0 : ((acc > PIXEL_MAX) ? PIXEL_MAX : acc[SAMPLE_W-1:0]);
         res.line_end = (raster_col + 1 >= len);
         pending_pixels.push_back(res);
      end

      raster_col++;
      if (raster_col >= len) begin
         raster_col = 0;
         if (rows_done < HIST_ROWS) rows_done++;
      end
   endtask

   function automatic void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endfunction

   // One byte on req; valid stays high after the transfer until the next call
   task automatic send_byte(input logic [SAMPLE_W-1:0] value, input logic start);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.sample      = value;
      req_ch.frame_start = start;
      do @(posedge clock); while (!req_ch.ready);
      convolve_byte(value, start);
      items_sent++;
   endtask

   // fill < 0 gives random bytes; noise_pct sprinkles stray frame starts
   task automatic send_stream(input int count, input logic first_start,
                              input int noise_pct, input int fill);
      logic start;
      for (int i = 0; i < count; i++) begin
         start = (i == 0) ? first_start : ($urandom_range(0, 99) < noise_pct);
         send_byte((fill < 0) ? pick_sample() : SAMPLE_W'(fill), start);
      end
   endtask

   // Stop sending until every expected byte is back and the pipeline is empty
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      int lane;
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_PADDED_LINE_PIXELS)
         line_pixels = value[LINE_PIX_W-1:0];
      else if (idx == CSR_COEF_WORD_6)
         kernel_coef[NUM_COEFS-1] = value[COEF_W-1:0];
      else
         for (lane = 0; lane < LANES; lane++)
            kernel_coef[int'(idx)*LANES + lane] = value[lane*COEF_W +: COEF_W];
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Unused upper data bits carry random junk
   task automatic set_line_pixels(input int unsigned pixels);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom, $urandom};
      word[LINE_PIX_W-1:0] = pixels[LINE_PIX_W-1:0];
      csr_write(CSR_PADDED_LINE_PIXELS, word);
   endtask

   task automatic load_kernel(input coef_vec_type taps);
      logic [CSR_DATA_W-1:0] word;
      int w;
      for (w = 0; w < (NUM_COEFS-1)/LANES; w++) begin
         word = {taps[LANES*w+3], taps[LANES*w+2], taps[LANES*w+1], taps[LANES*w]};
         csr_write(csr_index_type'(int'(CSR_COEF_WORD_0) + w), word);
      end
      word = {$urandom, $urandom};
      word[COEF_W-1:0] = taps[NUM_COEFS-1];
      csr_write(CSR_COEF_WORD_6, word);
   endtask

   // Untouched registers: 1024-pixel lines, so a short stream stays in the priming rows
   task automatic test_reset_state();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_stream(KERNEL_SIZE * line_len(KERNEL_SIZE), 1'b0, 0, -1);
      wait_idle();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Coefficient extremes on the narrowest line (width 0 acts as 5)
   task automatic test_kernel_extremes();
      coef_vec_type kernels [6];
      kernels[0] = {NUM_COEFS{16'h7FFF}};
      kernels[1] = {NUM_COEFS{16'h8000}};
      kernels[2] = {NUM_COEFS{16'hFFFF}};
      kernels[3] = {NUM_COEFS{16'h0001}};
      kernels[4] = '0;
      kernels[4][(NUM_COEFS-1)/2] = 16'h0001;
      kernels[5] = random_kernel(KERNEL_FULL);
      set_line_pixels(0);
      for (int i = 0; i < 6; i++) begin
         wait_idle();
         load_kernel(kernels[i]);
         // first kernel primes the frame, later ones add one output line each
         if (i == 0)
            send_stream(KERNEL_SIZE * line_len(0), 1'b1, 0, -1);
         else
            send_stream(line_len(0), 1'b0, 0, -1);
      end
      // saturated sum with all-max samples, then all-zero samples
      wait_idle();
      load_kernel(kernels[3]);
      send_stream(KERNEL_SIZE * line_len(0), 1'b1, 0, PIXEL_MAX);
      send_stream(KERNEL_SIZE * line_len(0), 1'b1, 0, 0);
      wait_idle();
   endtask

   // Smallest legal width, and a width far above the maximum (no output within 5 short lines)
   task automatic test_line_width_limits();
      set_line_pixels(KERNEL_SIZE);
      load_kernel(random_kernel(KERNEL_TAP));
      send_stream(KERNEL_SIZE * line_len(KERNEL_SIZE), 1'b1, 0, -1);
      wait_idle();
      set_line_pixels((1 << LINE_PIX_W) - 1);
      load_kernel(random_kernel(KERNEL_SPARSE));
      send_stream(KERNEL_SIZE * line_len(KERNEL_SIZE), 1'b1, 0, -1);
      wait_idle();
   endtask

   // Frame start in the priming rows and again in the middle of an output line
   task automatic test_frame_restart();
      int len;
      len = line_len(6);
      set_line_pixels(6);
      load_kernel(random_kernel(KERNEL_SPARSE));
      send_stream(2*len + 5, 1'b1, 0, -1);
      send_stream(HIST_ROWS*len + EMIT_COL + 2, 1'b1, 0, -1);
      send_stream(KERNEL_SIZE*len, 1'b1, 0, -1);
      wait_idle();
   endtask

   // Shrinking the line while a line is in progress
   task automatic test_mid_line_shrink();
      // column already past the new length: the line ends on the next byte
      set_line_pixels(12);
      load_kernel(random_kernel(KERNEL_TAP));
      send_stream(HIST_ROWS*line_len(12) + 25, 1'b1, 0, -1);
      wait_idle();
      set_line_pixels(0);
      send_stream(1 + 2*line_len(0), 1'b0, 0, -1);
      wait_idle();
      // column still short of the new length: the line just ends earlier
      set_line_pixels(12);
      send_stream(HIST_ROWS*line_len(12) + 10, 1'b1, 0, -1);
      wait_idle();
      set_line_pixels(8);
      send_stream(line_len(8) - 10 + 2*line_len(8), 1'b0, 0, -1);
      wait_idle();
   endtask

   // Whole frames of random size and content, with a few stray frame starts
   task automatic test_random_traffic();
      int               stop_at;
      int unsigned      width;
      int unsigned      narrow;
      int               len;
      int               total;
      int               split;
      kernel_style_type style;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         wait_idle();
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         style = kernel_style_type'($urandom_range(0, 2));
         load_kernel(random_kernel(style));
         width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KERNEL_SIZE-1)
                                             : $urandom_range(KERNEL_SIZE, 20);
         set_line_pixels(width);
         len   = line_len(width);
         total = $urandom_range(KERNEL_SIZE, 8) * len - $urandom_range(0, len-1);
         if ($urandom_range(0, 4) == 0) begin
            // pause mid-frame, then new coefficients or a narrower line
            split = $urandom_range(1, total-1);
            send_stream(split, 1'b1, 1, -1);
            wait_idle();
            if ($urandom_range(0, 1) == 0) begin
               load_kernel(random_kernel(style));
            end else begin
               narrow = $urandom_range(0, width);
               set_line_pixels(narrow);
            end
            send_stream(total - split, 1'b0, 1, -1);
         end else begin
            send_stream(total, 1'b1, 1, -1);
         end
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (pending_pixels.size() == 0) begin
            log_mismatch($sformatf("result %0d unexpected: pixel=%0d line_end=%0b",
                                   result_count, rsp_ch.pixel_out, rsp_ch.line_end));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_ch.pixel_out !== want.pixel || rsp_ch.line_end !== want.line_end)
               log_mismatch($sformatf(
                  "result %0d: expected pixel=%0d line_end=%0b, got pixel=%0d line_end=%0b",
                  result_count, want.pixel, want.line_end,
                  rsp_ch.pixel_out, rsp_ch.line_end));
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         if (rsp_stalls_on) stall_left = pick_gap();
      end
   end

   // Watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_COEF_WORD_0;
      csr_ch.data        = '0;
      kernel_coef        = '0;
      line_pixels        = LINE_PIX_W'(MAX_LINE_PIXELS);
      raster_col         = 0;
      rows_done          = 0;
      mismatch_count     = 0;
      result_count       = 0;
      items_sent         = 0;
      idle_cycles        = 0;
      stall_left         = 0;
      req_gaps_on        = 1'b1;
      rsp_stalls_on      = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_kernel_extremes();
      test_line_width_limits();
      test_frame_restart();
      test_mid_line_shrink();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
